// File: hw/rtl/rab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rab_pkg: shared constants for the ring arena block allocator
// Request and status codes, default geometry and port field widths.
// ----------------------------------------------------------------------------
package rab_pkg;

    localparam int ArenaBytesDef  = 4096;
    localparam int HeaderBytesDef = 20;

    localparam int TYPE_W   = 3;
    localparam int SIZE_W   = 13;
    localparam int ADDR_W   = 12;
    localparam int ID_W     = 15;
    localparam int STATUS_W = 2;

    localparam logic [TYPE_W-1:0] REQ_ALLOC   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_SHRINK  = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_LINK    = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_SET_ID  = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_FREE    = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_COLLECT = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_OWNER = 2'd2;

    localparam logic [15:0] OWNER_FREE = 16'hFFFF;

endpackage

// File: hw/rtl/ring_arena_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_arena_block_allocator_core: header store allocator over a byte ring
// Sequenced walk engine over a header store with one read and one write port.
// ----------------------------------------------------------------------------
// One request beat in, one result beat out. Each request is worked by a small
// sequencer that steps through a single header store (capacity, length,
// owner, link, one read port, registered read data, one write port) with one
// shared adder/comparator. Chain walks and collect scans visit one header at
// a time; alloc and shrink merge each free follower into the block. A shrink
// of size zero or an unused request code answers in the next cycle. Link
// walks to the chain tail and then paints the appended chain; a collect scans
// from the head (twice if it must wrap) and then sweeps the whole ring. After
// reset the store is cleared one entry a cycle and no request is taken
// meanwhile. The result sits in an output register; in_ready stays low while
// a request is in flight or a result waits.
// ----------------------------------------------------------------------------
module ring_arena_block_allocator_core
    import rab_pkg::*;
#(
    parameter int ARENA_BYTES  = ArenaBytesDef,
    parameter int HEADER_BYTES = HeaderBytesDef
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [TYPE_W-1:0]   req_type,
    input  logic [SIZE_W-1:0]   req_size,
    input  logic [ADDR_W-1:0]   block_addr,
    input  logic [ADDR_W-1:0]   other_block,
    input  logic [ID_W-1:0]     new_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   result_block,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     collected_id
);
    localparam int DEPTH = ARENA_BYTES / 4;
    localparam int WW    = $clog2(DEPTH);
    localparam int BW    = $clog2(ARENA_BYTES) + 2;   // byte arithmetic width
    localparam int LW    = WW + 1;                    // link: word index + 1
    localparam int CW    = WW + 1;                    // step counter

    localparam logic [BW-1:0] ARENA = BW'(ARENA_BYTES);
    localparam logic [BW-1:0] HDR   = BW'(HEADER_BYTES);

    // sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE  = 5'd1,  S_RD    = 5'd2,
                           S_WAIT  = 5'd3,  S_AHEAD = 5'd4,  S_ANXT  = 5'd5,
                           S_AMRG  = 5'd6,  S_AFIN  = 5'd7,  S_SPLIT = 5'd8,
                           S_LTAIL = 5'd9,  S_PAINT = 5'd10, S_LSET  = 5'd11,
                           S_CSCAN = 5'd12, S_CSWP  = 5'd13, S_OUT   = 5'd14,
                           S_AHW   = 5'd15, S_LOWN  = 5'd16;

    logic [4:0] state_reg, state_next, ret_reg, ret_next;

    // header store
    logic [BW-1:0] cap_mem [DEPTH];
    logic [BW-1:0] len_mem [DEPTH];
    logic [15:0]   own_mem [DEPTH];
    logic [LW-1:0] lnk_mem [DEPTH];

    logic [WW-1:0] raddr;
    logic [BW-1:0] rcap, rlen;
    logic [15:0]   rown;
    logic [LW-1:0] rlnk;
    logic          we_cap, we_len, we_own, we_lnk;
    logic [WW-1:0] waddr;
    logic [BW-1:0] wcap, wlen;
    logic [15:0]   wown;
    logic [LW-1:0] wlnk;

    always_ff @(posedge clk)
    begin
        if (we_cap) cap_mem[waddr] <= wcap;
        if (we_len) len_mem[waddr] <= wlen;
        if (we_own) own_mem[waddr] <= wown;
        if (we_lnk) lnk_mem[waddr] <= wlnk;
        rcap <= cap_mem[raddr];
        rlen <= len_mem[raddr];
        rown <= own_mem[raddr];
        rlnk <= lnk_mem[raddr];
    end

    // working registers
    logic [TYPE_W-1:0] op_reg, op_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [WW-1:0]     blk_reg, blk_next, oth_reg, oth_next;
    logic [WW-1:0]     w_reg, w_next, n_reg, n_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [BW-1:0]     cap_reg, cap_next;
    logic [15:0]       id_reg, id_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pass_reg, pass_next, has_reg, has_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [ID_W-1:0]   col_reg, col_next;

    // shared adder / compare
    logic [BW-1:0] pos_w, sum, need, total;
    logic          seq_ok;
    assign pos_w  = {w_reg, 2'b00};
    assign sum    = pos_w + rcap;                 // end of block w_reg
    assign seq_ok = (rcap != '0) && (sum < ARENA);
    assign total  = BW'(size_reg) + HDR;
    assign need   = (total + BW'(3)) & ~BW'(3);

    function automatic logic [WW-1:0] word_of(input logic [BW-1:0] b);
        return b[WW+1:2];
    endfunction

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign result_block = res_reg;
    assign status       = st_reg;
    assign collected_id = col_reg;

    always_comb
    begin
        logic [BW-1:0] t;
        t = '0;
        state_next = state_reg; ret_next = ret_reg;
        op_next = op_reg; size_next = size_reg; blk_next = blk_reg;
        oth_next = oth_reg; w_next = w_reg; n_next = n_reg;
        head_next = head_reg; cap_next = cap_reg; id_next = id_reg;
        cnt_next = cnt_reg; pass_next = pass_reg; has_next = has_reg;
        res_next = res_reg; st_next = st_reg; col_next = col_reg;
        raddr = w_reg;
        we_cap = 1'b0; we_len = 1'b0; we_own = 1'b0; we_lnk = 1'b0;
        waddr = w_reg; wcap = '0; wlen = '0; wown = '0; wlnk = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                waddr = cnt_reg[WW-1:0];
                we_cap = 1'b1; we_len = 1'b1; we_own = 1'b1; we_lnk = 1'b1;
                if (cnt_reg == '0)
                begin
                    wcap = ARENA; wlen = ARENA; wown = OWNER_FREE;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = req_type; size_next = req_size;
                    blk_next = word_of(BW'(block_addr));
                    oth_next = word_of(BW'(other_block));
                    id_next = {1'b0, new_id};
                    res_next = '0; st_next = ST_DONE; col_next = '0;
                    pass_next = 1'b0; cnt_next = '0;
                    unique case (req_type)
                        REQ_ALLOC:
                        begin
                            w_next = word_of(BW'(head_reg));
                            ret_next = S_AHEAD; state_next = S_RD;
                        end
                        REQ_SHRINK:
                        begin
                            w_next = word_of(BW'(block_addr));
                            if (req_size == '0)
                            begin
                                head_next = {word_of(BW'(block_addr)), 2'b00};
                                state_next = S_OUT;
                            end
                            else
                            begin
                                ret_next = S_ANXT; state_next = S_RD;
                            end
                        end
                        REQ_LINK:
                        begin
                            w_next = word_of(BW'(block_addr));
                            ret_next = S_LTAIL; state_next = S_RD;
                        end
                        REQ_SET_ID:
                        begin
                            w_next = word_of(BW'(block_addr));
                            ret_next = S_PAINT; state_next = S_RD;
                        end
                        REQ_FREE:
                        begin
                            w_next = word_of(BW'(block_addr));
                            id_next = OWNER_FREE;
                            ret_next = S_PAINT; state_next = S_RD;
                        end
                        REQ_COLLECT:
                        begin
                            w_next = word_of(BW'(head_reg));
                            ret_next = S_CSCAN; state_next = S_RD;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_RD:   state_next = S_WAIT;          // address presented
            S_WAIT: state_next = ret_reg;         // data registered
            S_AHEAD:
            begin
                // head block of an alloc pass
                if (rown != OWNER_FREE)
                begin
                    if (head_reg == '0)
                    begin
                        st_next = ST_NO_SPACE; state_next = S_OUT;
                    end
                    else
                    begin
                        head_next = '0; w_next = '0; ret_next = S_AHEAD;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    cap_next = rcap; cnt_next = '0; ret_next = S_ANXT;
                    state_next = S_WAIT;
                end
            end
            S_ANXT:
            begin
                // rcap/cap_reg is w's capacity; find sequential follower
                if (!seq_ok || cnt_reg == CW'(DEPTH))
                begin
                    has_next = seq_ok;
                    n_next = word_of(sum);
                    state_next = S_AFIN;
                end
                else
                begin
                    n_next = word_of(sum);
                    raddr = word_of(sum);
                    cap_next = rcap;
                    ret_next = S_AMRG; state_next = S_AHW;
                end
            end
            S_AHW:
            begin
                // keep the follower on the read port
                raddr = n_reg;
                state_next = S_AMRG;
            end
            S_AMRG:
            begin
                // rown/rcap belong to follower n_reg
                if (rown != OWNER_FREE)
                begin
                    has_next = 1'b1; state_next = S_AFIN;
                end
                else
                begin
                    t = cap_reg + rcap;
                    if (t > ARENA - pos_w)
                        t = ARENA - pos_w;
                    we_cap = 1'b1; wcap = t;
                    cnt_next = cnt_reg + 1'b1;
                    ret_next = S_ANXT; state_next = S_RD;
                end
            end
            S_AFIN:
            begin
                raddr = w_reg;
                if (op_reg == REQ_ALLOC)
                begin
                    we_len = 1'b1; wlen = rcap;
                    if (size_reg == '0)
                    begin
                        head_next = has_reg ? {n_reg, 2'b00} : '0;
                        we_lnk = 1'b0;
                        res_next = {w_reg, 2'b00};
                        state_next = S_SPLIT; cnt_next = '1;
                    end
                    else if (total > rcap)
                    begin
                        if (head_reg == '0)
                        begin
                            st_next = ST_NO_SPACE; state_next = S_OUT;
                        end
                        else
                        begin
                            head_next = '0; w_next = '0; ret_next = S_AHEAD;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        res_next = {w_reg, 2'b00};
                        cap_next = rcap; state_next = S_SPLIT; cnt_next = '0;
                    end
                end
                else
                begin
                    cap_next = rcap; state_next = S_SPLIT; cnt_next = '0;
                end
            end
            S_SPLIT:
            begin
                // cnt all ones: alloc of size zero, only clear link
                if (cnt_reg == '1)
                begin
                    we_lnk = 1'b1; wlnk = '0; state_next = S_OUT;
                end
                else if (cnt_reg == '0)
                begin
                    we_len = 1'b1; wlen = total;
                    if (cap_reg >= need && (cap_reg - need) > HDR)
                    begin
                        we_cap = 1'b1; wcap = need;
                        n_next = word_of(pos_w + need);
                        head_next = {word_of(pos_w + need), 2'b00};
                        cnt_next = CW'(1);
                    end
                    else
                    begin
                        head_next = has_reg ? {n_reg, 2'b00} : '0;
                        cnt_next = CW'(2);
                    end
                end
                else if (cnt_reg == CW'(1))
                begin
                    waddr = n_reg;
                    we_cap = 1'b1; we_len = 1'b1; we_own = 1'b1; we_lnk = 1'b1;
                    wcap = cap_reg - need; wlen = cap_reg - need;
                    wown = OWNER_FREE; wlnk = '0;
                    cnt_next = CW'(2);
                end
                else
                begin
                    if (op_reg == REQ_ALLOC)
                    begin
                        we_lnk = 1'b1; wlnk = '0;
                    end
                    state_next = S_OUT;
                end
            end
            S_LTAIL:
            begin
                if (rlnk == '0 || rlnk > LW'(DEPTH) || cnt_reg == CW'(DEPTH))
                begin
                    blk_next = w_reg;  // tail
                    id_next = rown;
                    w_next = oth_reg; cnt_next = '0;
                    ret_next = S_PAINT; state_next = S_RD;
                end
                else
                begin
                    w_next = WW'(rlnk - 1'b1);
                    cnt_next = cnt_reg + 1'b1;
                    ret_next = S_LTAIL; state_next = S_RD;
                end
            end
            S_PAINT:
            begin
                we_own = 1'b1; wown = id_reg;
                cnt_next = cnt_reg + 1'b1;
                if (rlnk == '0 || rlnk > LW'(DEPTH) || cnt_reg == CW'(DEPTH - 1))
                    state_next = (op_reg == REQ_LINK) ? S_LSET : S_OUT;
                else
                begin
                    w_next = WW'(rlnk - 1'b1);
                    ret_next = S_PAINT; state_next = S_RD;
                end
            end
            S_LSET:
            begin
                waddr = blk_reg; we_lnk = 1'b1; wlnk = LW'(oth_reg) + 1'b1;
                state_next = S_OUT;
            end
            S_LOWN: state_next = S_OUT;
            S_CSCAN:
            begin
                if (rlen >= HDR && rown != OWNER_FREE)
                begin
                    id_next = rown; w_next = '0; cnt_next = '0;
                    ret_next = S_CSWP; state_next = S_RD;
                end
                else if (!seq_ok || cnt_reg == CW'(DEPTH - 1))
                begin
                    head_next = '0;
                    if (pass_reg)
                    begin
                        st_next = ST_NO_OWNER; state_next = S_OUT;
                    end
                    else
                    begin
                        pass_next = 1'b1; w_next = '0; cnt_next = '0;
                        ret_next = S_CSCAN; state_next = S_RD;
                    end
                end
                else
                begin
                    w_next = word_of(sum); cnt_next = cnt_reg + 1'b1;
                    ret_next = S_CSCAN; state_next = S_RD;
                end
            end
            S_CSWP:
            begin
                if (rlen >= HDR && rown == id_reg)
                begin
                    we_own = 1'b1; wown = OWNER_FREE;
                end
                if (!seq_ok || cnt_reg == CW'(DEPTH - 1))
                begin
                    col_next = id_reg[ID_W-1:0]; state_next = S_OUT;
                end
                else
                begin
                    w_next = word_of(sum); cnt_next = cnt_reg + 1'b1;
                    ret_next = S_CSWP; state_next = S_RD;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next; op_reg <= op_next; size_reg <= size_next;
        blk_reg <= blk_next; oth_reg <= oth_next; w_reg <= w_next;
        n_reg <= n_next; cap_reg <= cap_next; id_reg <= id_next;
        pass_reg <= pass_next; has_reg <= has_next; res_reg <= res_next;
        st_reg <= st_next; col_reg <= col_next;
    end

endmodule

// File: hw/rtl/rab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rab_checker: port-level checks for the block allocator
// Watches the beats on both channels of the top level.
// ----------------------------------------------------------------------------
module rab_checker
    import rab_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [ADDR_W-1:0]   result_block,
    input logic [ID_W-1:0]     collected_id
);
    // one request in flight: no new beat while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // a taken request beat closes the input until its result has gone
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready straight after a request beat");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped before taken");

    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> result_block == '0)
        else $error("failed request with block offset");

    a_nocol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NO_OWNER |-> collected_id == '0)
        else $error("id reported for empty collect");
endmodule

bind ring_arena_block_allocator_core rab_checker u_rab_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .result_block(result_block), .collected_id(collected_id)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ring_arena_block_allocator_core
// Keeps its own copy of the header store and ring head, predicts the result
// beat of every accepted request and checks it against the block's output.
// A directed opening is followed by random traffic with bursty requests and
// a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    import rab_pkg::*;

    localparam int ARENA  = ArenaBytesDef;
    localparam int HDR    = HeaderBytesDef;
    localparam int WORDS  = ARENA / 4;
    localparam int N_RAND = 2000;
    localparam int STALL_LIMIT = 60000;
    localparam logic [TYPE_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_SPARE7 = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0]   blk;
        logic [STATUS_W-1:0] st;
        logic [ID_W-1:0]     cid;
    } result_t;

    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] other;
        logic [ID_W-1:0]   id;
    } request_t;

    // Mirror of the header store plus the expected result beats.
    class arena_tracker;
        bit [12:0] cap [WORDS];
        bit [12:0] len [WORDS];
        bit [15:0] owner [WORDS];
        bit [10:0] link [WORDS];
        bit        link_known [WORDS];
        bit [11:0] head;
        result_t   pending_results [$];
        int unsigned alloc_words [$];
        int        mismatches;

        function new();
            for (int i = 0; i < WORDS; i++)
            begin
                cap[i] = 0; len[i] = 0; owner[i] = 0; link[i] = 0; link_known[i] = 0;
            end
            cap[0] = 13'(ARENA); len[0] = 13'(ARENA); owner[0] = OWNER_FREE;
            head = 0;
            mismatches = 0;
        endfunction

        function bit seq_next(int unsigned w, output int unsigned n);
            int unsigned pos;
            int unsigned c;
            pos = w * 4;
            c = cap[w];
            n = w;
            if (c == 0 || pos + c >= ARENA)
                return 0;
            n = ((pos + c) >> 2) % WORDS;
            return 1;
        endfunction

        function bit chain_next(int unsigned w, output int unsigned n);
            int unsigned l;
            l = link[w];
            n = w;
            if (l == 0 || l > WORDS)
                return 0;
            n = l - 1;
            return 1;
        endfunction

        function bit absorb_free(int unsigned w, output int unsigned n);
            int unsigned pos;
            int unsigned t;
            pos = w * 4;
            for (int s = 0; s < WORDS; s++)
            begin
                if (!seq_next(w, n))
                    return 0;
                if (owner[n] != OWNER_FREE)
                    return 1;
                t = cap[w] + cap[n];
                if (pos + t > ARENA)
                    t = ARENA - pos;
                cap[w] = 13'(t);
            end
            return seq_next(w, n);
        endfunction

        function void carve(int unsigned w, int unsigned total, bit has, int unsigned nxt);
            int unsigned c;
            int unsigned need;
            int unsigned s;
            c = cap[w];
            need = (total + 3) & ~32'd3;
            len[w] = 13'(total);
            if (c >= need && c - need > HDR)
            begin
                s = ((w * 4 + need) >> 2) % WORDS;
                cap[w] = 13'(need);
                cap[s] = 13'(c - need);
                len[s] = 13'(c - need);
                owner[s] = OWNER_FREE;
                link[s] = 0;
                link_known[s] = 1;
                head = 12'(s * 4);
            end
            else
                head = has ? 12'(nxt * 4) : 12'd0;
        endfunction

        function void paint(int unsigned w, int unsigned id);
            int unsigned n;
            for (int s = 0; s < WORDS; s++)
            begin
                owner[w] = 16'(id);
                if (!chain_next(w, n))
                    return;
                w = n;
            end
        endfunction

        function int unsigned tail_of(int unsigned w);
            int unsigned n;
            for (int s = 0; s < WORDS; s++)
            begin
                if (!chain_next(w, n))
                    break;
                w = n;
            end
            return w;
        endfunction

        // True if target lies on the chain starting at w (link would close a loop).
        function bit on_chain(int unsigned w, int unsigned target);
            int unsigned n;
            for (int s = 0; s < WORDS; s++)
            begin
                if (w == target)
                    return 1;
                if (!chain_next(w, n))
                    return 0;
                w = n;
            end
            return 0;
        endfunction

        function bit do_alloc(int unsigned size, output int unsigned where);
            int unsigned w;
            int unsigned nxt;
            bit has;
            where = 0;
            for (int pass = 0; pass < 2; pass++)
            begin
                w = (head >> 2) % WORDS;
                nxt = 0;
                if (owner[w] != OWNER_FREE)
                begin
                    if (head == 0)
                        return 0;
                    head = 0;
                    continue;
                end
                has = absorb_free(w, nxt);
                len[w] = cap[w];
                if (size == 0)
                    head = has ? 12'(nxt * 4) : 12'd0;
                else
                begin
                    if (size + HDR > cap[w])
                    begin
                        if (head == 0)
                            return 0;
                        head = 0;
                        continue;
                    end
                    carve(w, size + HDR, has, nxt);
                end
                link[w] = 0;
                link_known[w] = 1;
                where = w * 4;
                return 1;
            end
            return 0;
        endfunction

        function bit do_collect(output int unsigned id_out);
            int unsigned w;
            int unsigned n;
            int unsigned id;
            bit found;
            id = 0;
            found = 0;
            id_out = 0;
            for (int pass = 0; pass < 2 && !found; pass++)
            begin
                w = (head >> 2) % WORDS;
                for (int s = 0; s < WORDS; s++)
                begin
                    if (len[w] >= HDR && owner[w] != OWNER_FREE)
                    begin
                        id = owner[w];
                        found = 1;
                        break;
                    end
                    if (!seq_next(w, n))
                        break;
                    w = n;
                end
                if (!found)
                    head = 0;
            end
            if (!found)
                return 0;
            w = 0;
            for (int s = 0; s < WORDS; s++)
            begin
                if (len[w] >= HDR && owner[w] == id)
                    owner[w] = OWNER_FREE;
                if (!seq_next(w, n))
                    break;
                w = n;
            end
            id_out = id;
            return 1;
        endfunction

        function void note_request(request_t r);
            result_t e;
            int unsigned blk;
            int unsigned oth;
            int unsigned res;
            int unsigned coll;
            int unsigned nxt;
            int unsigned t;
            bit has;
            blk = (r.addr >> 2) % WORDS;
            oth = (r.other >> 2) % WORDS;
            e = '0;
            case (r.kind)
                REQ_ALLOC:
                begin
                    if (do_alloc(r.size, res))
                    begin
                        e.blk = ADDR_W'(res);
                        alloc_words.push_back(res >> 2);
                        if (alloc_words.size() > 48)
                            void'(alloc_words.pop_front());
                    end
                    else
                        e.st = ST_NO_SPACE;
                end
                REQ_SHRINK:
                begin
                    if (r.size == 0)
                        head = 12'(blk * 4);
                    else
                    begin
                        nxt = 0;
                        has = absorb_free(blk, nxt);
                        carve(blk, r.size + HDR, has, nxt);
                    end
                end
                REQ_LINK:
                begin
                    t = tail_of(blk);
                    paint(oth, owner[t]);
                    link[t] = 11'(oth + 1);
                    link_known[t] = 1;
                end
                REQ_SET_ID: paint(blk, r.id);
                REQ_FREE:   paint(blk, OWNER_FREE);
                REQ_COLLECT:
                begin
                    if (do_collect(coll))
                        e.cid = ID_W'(coll);
                    else
                        e.st = ST_NO_OWNER;
                end
                default: ;
            endcase
            pending_results.push_back(e);
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat blk=%0d st=%0d id=%0d",
                             got.blk, got.st, got.cid);
                return;
            end
            e = pending_results.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp blk=%0d st=%0d id=%0d, got blk=%0d st=%0d id=%0d",
                             e.blk, e.st, e.cid, got.blk, got.st, got.cid);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [TYPE_W-1:0]   req_type = '0;
    logic [SIZE_W-1:0]   req_size = '0;
    logic [ADDR_W-1:0]   block_addr = '0;
    logic [ADDR_W-1:0]   other_block = '0;
    logic [ID_W-1:0]     new_id = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [ADDR_W-1:0]   result_block;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     collected_id;

    arena_tracker arena = new();
    int results_seen = 0;
    int idle_cycles = 0;
    int loops_made = 0;

    ring_arena_block_allocator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .req_size     (req_size),
        .block_addr   (block_addr),
        .other_block  (other_block),
        .new_id       (new_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_block (result_block),
        .status       (status),
        .collected_id (collected_id)
    );

    always #5 clk = ~clk;

    // Result monitor: every output beat goes straight to the tracker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            arena.check_result({result_block, status, collected_id});
            results_seen++;
        end
    end

    // Watchdog on cycles with no beat on either channel (covers the clear pass).
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** ring_arena_block_allocator_core: FAILED **");
            $finish;
        end
    end

    // Receiver: changing stall pattern, plus two long hold-offs so that a
    // waiting result blocks the request side while the sender keeps offering.
    initial
    begin : receiver
        int mode;
        int phase;
        int hold;
        bit held_a;
        bit held_b;
        mode = 0; phase = 0; hold = 0; held_a = 0; held_b = 0;
        forever
        begin
            @(posedge clk);
            if (!held_a && results_seen >= 60) begin held_a = 1; hold = 400; end
            if (!held_b && results_seen >= 1500) begin held_b = 1; hold = 250; end
            if (phase == 0)
            begin
                mode = $urandom_range(0, 3);
                phase = $urandom_range(20, 200);
            end
            phase--;
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 0);
                    2: out_ready <= ($urandom_range(0, 9) != 0);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
        end
    end

    // One request beat; valid stays up until accepted, then the tracker is told.
    task automatic send_request(request_t r);
        in_valid    <= 1'b1;
        req_type    <= r.kind;
        req_size    <= r.size;
        block_addr  <= r.addr;
        other_block <= r.other;
        new_id      <= r.id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        arena.note_request(r);
    endtask

    // Byte address of a block whose link entry is known; low bits are noise.
    function automatic int chain_addr(int k);
        int unsigned w;
        if (arena.alloc_words.size() == 0)
            return -1;
        w = arena.alloc_words[k % arena.alloc_words.size()];
        if (!arena.link_known[w])
            return -1;
        return w * 4 + $urandom_range(0, 3);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return ID_W'($urandom);
            default: return ID_W'($urandom_range(0, 6));
        endcase
    endfunction

    // Chain requests on blocks of unknown link fall back to an alloc; links
    // that would close a loop are kept rare since their walks are long.
    function automatic request_t make_safe(request_t r);
        int a;
        int b;
        int unsigned t;
        if (r.kind inside {REQ_LINK, REQ_SET_ID, REQ_FREE})
        begin
            a = chain_addr($urandom);
            b = chain_addr($urandom);
            if (a < 0 || b < 0)
            begin
                r.kind = REQ_ALLOC;
                return r;
            end
            r.addr = ADDR_W'(a);
            if (r.kind == REQ_LINK)
            begin
                r.other = ADDR_W'(b);
                t = arena.tail_of(a >> 2);
                if (arena.on_chain(b >> 2, t))
                begin
                    if (loops_made >= 2)
                        r.kind = REQ_SET_ID;
                    else
                        loops_made++;
                end
            end
        end
        return r;
    endfunction

    function automatic request_t directed_request(int k);
        request_t r;
        r.kind  = REQ_ALLOC;
        r.size  = SIZE_W'($urandom_range(0, 300));
        r.addr  = ADDR_W'($urandom);
        r.other = ADDR_W'($urandom);
        r.id    = ID_W'($urandom);
        case (k)
            0:  r.size = SIZE_W'(4096);              // too big from head zero
            1:  r.size = SIZE_W'(1);
            2:  r.size = SIZE_W'(100);
            3:  r.size = SIZE_W'(4095 - 3 * HDR);
            4:  r.size = '0;                         // takes the rest whole
            5:  begin r.kind = REQ_SET_ID; r.id = '1; end
            6:  begin r.kind = REQ_SET_ID; r.id = '0; end
            7:  r.kind = REQ_LINK;
            8:  r.kind = REQ_COLLECT;
            9:  r.kind = REQ_COLLECT;
            10: r.kind = REQ_COLLECT;                // nothing live left
            11: begin r.kind = REQ_SHRINK; r.size = '0; r.addr = 12'hFFF; end
            12: begin r.kind = REQ_SHRINK; r.size = SIZE_W'(4096); r.addr = '0; end
            13: begin r.kind = REQ_SHRINK; r.size = SIZE_W'(3); r.addr = '0; end
            14: r.kind = REQ_SPARE6;
            15: r.kind = REQ_SPARE7;
            16: r.kind = REQ_FREE;
            17: r.size = SIZE_W'(4096);
            18: r.size = '0;
            19: begin r.kind = REQ_SET_ID; r.id = 15'h5555; end
            20: r.kind = REQ_COLLECT;
            default: r.size = SIZE_W'(8);
        endcase
        if (k == 5 || k == 6 || k == 7 || k == 16 || k == 19)
            return make_safe(r);
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int pick;
        r.size  = SIZE_W'($urandom_range(0, 4096));
        r.addr  = ADDR_W'($urandom);
        r.other = ADDR_W'($urandom);
        r.id    = pick_id();
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            r.kind = REQ_ALLOC;
            case ($urandom_range(0, 9))
                0:       r.size = '0;
                1:       r.size = SIZE_W'($urandom_range(0, 4096));
                default: r.size = SIZE_W'($urandom_range(1, 300));
            endcase
        end
        else if (pick < 45)
        begin
            r.kind = REQ_SHRINK;
            if ($urandom_range(0, 3) != 0 && chain_addr(0) >= 0)
                r.addr = ADDR_W'(chain_addr($urandom));
            if ($urandom_range(0, 2) != 0)
                r.size = SIZE_W'($urandom_range(0, 200));
        end
        else if (pick < 60)
            r.kind = REQ_LINK;
        else if (pick < 75)
            r.kind = REQ_SET_ID;
        else if (pick < 85)
            r.kind = REQ_FREE;
        else if (pick < 97)
            r.kind = REQ_COLLECT;
        else
            r.kind = ($urandom_range(0, 1) == 0) ? REQ_SPARE6 : REQ_SPARE7;
        return make_safe(r);
    endfunction

    initial
    begin : stimulus
        int burst;
        int gap;
        int wait_cnt;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        burst = 0;
        for (int i = 0; i < 21 + N_RAND; i++)
        begin
            if (burst == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                // valid only drops when a real gap follows
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 25);
            end
            burst--;
            send_request(i < 21 ? directed_request(i) : random_request());
        end
        in_valid <= 1'b0;
        wait_cnt = 0;
        while (arena.pending_results.size() != 0 && wait_cnt < STALL_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (100) @(posedge clk);
        if (arena.mismatches == 0 && arena.pending_results.size() == 0)
            $display("** ring_arena_block_allocator_core: PASSED **");
        else
            $display("** ring_arena_block_allocator_core: FAILED **");
        $finish;
    end

endmodule
